>>> rtl/fpbc_pkg.sv
// Package for the free page block cache: widths, codes, item and control types.
`timescale 1ns / 1ps
package fpbc_pkg;

  localparam int ENTRIES        = 32;
  localparam int PAGE_ADDR_BITS = 32;
  localparam int SIZE_BITS      = 20;
  localparam int IDX_W          = $clog2(ENTRIES);
  localparam int CNT_W          = $clog2(ENTRIES + 1);
  localparam int TOTAL_W        = SIZE_BITS + 1;
  localparam int MAXP_W         = 20;
  localparam int CAP_W          = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 20;

  localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(16384);
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(1);

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [2:0] ACT_HIT     = 3'd0;
  localparam logic [2:0] ACT_REQUEST = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_CACHED  = 3'd3;
  localparam logic [2:0] ACT_NOTHING = 3'd4;

  typedef struct packed {
    logic [1:0]                func;
    logic [SIZE_BITS-1:0]      size_pages;
    logic [PAGE_ADDR_BITS-1:0] block_page;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                action;
    logic [PAGE_ADDR_BITS-1:0] block_page_res;
    logic [SIZE_BITS-1:0]      size_pages_res;
    logic                      last;
  } out_item_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_SCAN_NEXT,
    DP_DROP_IDX,
    DP_DROP_HEAD,
    DP_APPEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]                func;
    logic [SIZE_BITS-1:0]      size;
    logic [PAGE_ADDR_BITS-1:0] page;
    logic                      count_zero;
    logic                      count_one;
    logic                      size_zero;
    logic                      size_le_quarter;
    logic                      match;
    logic                      idx_last;
    logic                      evict_needed;
    logic [PAGE_ADDR_BITS-1:0] head_page;
    logic [SIZE_BITS-1:0]      head_size;
    logic [PAGE_ADDR_BITS-1:0] scan_page;
  } dp_stat_t;

endpackage

>>> rtl/fpbc_datapath.sv
// Datapath of the free page block cache: config, item latch, block list and totals.
`timescale 1ns / 1ps
module fpbc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [fpbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  fpbc_pkg::in_item_t               in_data,
  input  fpbc_pkg::dp_cmd_t                cmd,
  output fpbc_pkg::dp_stat_t               stat
);

  logic [fpbc_pkg::MAXP_W-1:0]         max_pages_r;
  logic [fpbc_pkg::CAP_W-1:0]          cap_r;
  logic [1:0]                          func_r;
  logic [fpbc_pkg::SIZE_BITS-1:0]      size_r;
  logic [fpbc_pkg::PAGE_ADDR_BITS-1:0] page_r;
  logic [fpbc_pkg::IDX_W-1:0]          scan_idx_r;
  logic [fpbc_pkg::CNT_W-1:0]          count_r;
  logic [fpbc_pkg::TOTAL_W-1:0]        total_r;
  logic [fpbc_pkg::PAGE_ADDR_BITS-1:0] addr_mem_r [fpbc_pkg::ENTRIES];
  logic [fpbc_pkg::SIZE_BITS-1:0]      size_mem_r [fpbc_pkg::ENTRIES];

  logic [fpbc_pkg::CNT_W-1:0]          cap_eff;
  logic [fpbc_pkg::IDX_W-1:0]          drop_idx;
  logic [fpbc_pkg::SIZE_BITS-1:0]      drop_size;
  logic [fpbc_pkg::SIZE_BITS-1:0]      scan_size;
  logic [fpbc_pkg::TOTAL_W:0]          total_plus;
  logic                                drop;

  // Effective capacity: zero acts as one, values above the depth clamp.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = fpbc_pkg::CNT_W'(1);
    end else if (int'(cap_r) > fpbc_pkg::ENTRIES) begin
      cap_eff = fpbc_pkg::CNT_W'(fpbc_pkg::ENTRIES);
    end else begin
      cap_eff = fpbc_pkg::CNT_W'(cap_r);
    end
  end

  assign drop      = (cmd.op == fpbc_pkg::DP_DROP_IDX) || (cmd.op == fpbc_pkg::DP_DROP_HEAD);
  assign drop_idx  = (cmd.op == fpbc_pkg::DP_DROP_HEAD) ? '0 : scan_idx_r;
  assign scan_size = size_mem_r[scan_idx_r];
  assign drop_size = (cmd.op == fpbc_pkg::DP_DROP_HEAD) ? size_mem_r[0] : scan_size;
  assign total_plus = {1'b0, total_r} + (fpbc_pkg::TOTAL_W + 1)'(size_r);

  always_comb begin
    stat.func            = func_r;
    stat.size            = size_r;
    stat.page            = page_r;
    stat.count_zero      = (count_r == '0);
    stat.count_one       = (count_r == fpbc_pkg::CNT_W'(1));
    stat.size_zero       = (size_r == '0);
    stat.size_le_quarter = (32'(size_r) <= 32'(max_pages_r >> 2));
    stat.match           = (scan_size == size_r);
    stat.idx_last        = ((fpbc_pkg::CNT_W'(scan_idx_r) + fpbc_pkg::CNT_W'(1)) == count_r);
    stat.evict_needed    = (count_r != '0) &&
                           ((count_r >= cap_eff) ||
                            (total_plus > (fpbc_pkg::TOTAL_W + 1)'(max_pages_r)));
    stat.head_page       = addr_mem_r[0];
    stat.head_size       = size_mem_r[0];
    stat.scan_page       = addr_mem_r[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r <= fpbc_pkg::MAXP_RESET;
      cap_r       <= fpbc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == fpbc_pkg::CFG_MAX_PAGES) begin
        max_pages_r <= fpbc_pkg::MAXP_W'(cfg_data);
      end else if (cfg_index == fpbc_pkg::CFG_CAPACITY) begin
        cap_r <= fpbc_pkg::CAP_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      count_r    <= '0;
      total_r    <= '0;
    end else begin
      case (cmd.op)
        fpbc_pkg::DP_LOAD:      scan_idx_r <= '0;
        fpbc_pkg::DP_SCAN_NEXT: scan_idx_r <= scan_idx_r + fpbc_pkg::IDX_W'(1);
        fpbc_pkg::DP_DROP_IDX,
        fpbc_pkg::DP_DROP_HEAD: begin
          count_r <= count_r - fpbc_pkg::CNT_W'(1);
          total_r <= total_r - fpbc_pkg::TOTAL_W'(drop_size);
        end
        fpbc_pkg::DP_APPEND: begin
          count_r <= count_r + fpbc_pkg::CNT_W'(1);
          total_r <= total_r + fpbc_pkg::TOTAL_W'(size_r);
        end
        default: ;
      endcase
    end
  end

  // Item latch and block list; entries above the count are don't-care.
  always_ff @(posedge clk) begin
    if (cmd.op == fpbc_pkg::DP_LOAD) begin
      func_r <= in_data.func;
      size_r <= in_data.size_pages;
      page_r <= in_data.block_page;
    end
    if (drop) begin
      for (int i = 0; i < fpbc_pkg::ENTRIES - 1; i++) begin
        if (i >= int'(drop_idx)) begin
          addr_mem_r[i] <= addr_mem_r[i+1];
          size_mem_r[i] <= size_mem_r[i+1];
        end
      end
    end
    if (cmd.op == fpbc_pkg::DP_APPEND) begin
      addr_mem_r[count_r[fpbc_pkg::IDX_W-1:0]] <= page_r;
      size_mem_r[count_r[fpbc_pkg::IDX_W-1:0]] <= size_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fpbc_pkg::CNT_W'(fpbc_pkg::ENTRIES))
    else $error("block count above store depth");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("empty list with nonzero page total");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fpbc_pkg::DP_APPEND) |-> (count_r < cap_eff))
    else $error("append into a full list");

endmodule

>>> rtl/fpbc_ctrl.sv
// Controller of the free page block cache: sequencing FSM and result register.
`timescale 1ns / 1ps
module fpbc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpbc_pkg::out_item_t  out_data,
  output fpbc_pkg::dp_cmd_t    cmd,
  input  fpbc_pkg::dp_stat_t   stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_EVICT,
    S_RELALL
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  fpbc_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_free;
  logic                emit;
  fpbc_pkg::out_item_t res;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = fpbc_pkg::DP_NOP;
    emit      = 1'b0;
    res       = '{action: fpbc_pkg::ACT_NOTHING, block_page_res: '0,
                  size_pages_res: '0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fpbc_pkg::DP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.func)
          fpbc_pkg::FUNC_ALLOC: begin
            if (!stat.count_zero && stat.size_le_quarter) begin
              state_nxt = S_SCAN;
            end else begin
              res.action         = fpbc_pkg::ACT_REQUEST;
              res.size_pages_res = stat.size;
              emit               = out_free;
            end
          end
          fpbc_pkg::FUNC_FREE: begin
            if (stat.size_zero) begin
              emit = out_free;
            end else if (!stat.size_le_quarter) begin
              res.action         = fpbc_pkg::ACT_RELEASE;
              res.block_page_res = stat.page;
              res.size_pages_res = stat.size;
              emit               = out_free;
            end else begin
              state_nxt = S_EVICT;
            end
          end
          fpbc_pkg::FUNC_RELEASE: begin
            if (stat.count_zero) begin
              emit = out_free;
            end else begin
              state_nxt = S_RELALL;
            end
          end
          default: emit = out_free;
        endcase
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.match) begin
          res.action         = fpbc_pkg::ACT_HIT;
          res.block_page_res = stat.scan_page;
          res.size_pages_res = stat.size;
          emit               = out_free;
          if (out_free) begin
            cmd.op    = fpbc_pkg::DP_DROP_IDX;
            state_nxt = S_IDLE;
          end
        end else if (stat.idx_last) begin
          res.action         = fpbc_pkg::ACT_REQUEST;
          res.size_pages_res = stat.size;
          emit               = out_free;
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = fpbc_pkg::DP_SCAN_NEXT;
        end
      end
      S_EVICT: begin
        emit = out_free;
        if (stat.evict_needed) begin
          res.action         = fpbc_pkg::ACT_RELEASE;
          res.block_page_res = stat.head_page;
          res.size_pages_res = stat.head_size;
          res.last           = 1'b0;
          if (out_free) begin
            cmd.op = fpbc_pkg::DP_DROP_HEAD;
          end
        end else begin
          res.action         = fpbc_pkg::ACT_CACHED;
          res.block_page_res = stat.page;
          res.size_pages_res = stat.size;
          if (out_free) begin
            cmd.op    = fpbc_pkg::DP_APPEND;
            state_nxt = S_IDLE;
          end
        end
      end
      S_RELALL: begin
        res.action         = fpbc_pkg::ACT_RELEASE;
        res.block_page_res = stat.head_page;
        res.size_pages_res = stat.head_size;
        res.last           = stat.count_one;
        emit               = out_free;
        if (out_free) begin
          cmd.op = fpbc_pkg::DP_DROP_HEAD;
          if (stat.count_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_load_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECIDE))
    else $error("accepted item did not enter decode");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.last) |=> (state_r == S_IDLE))
    else $error("final result did not end the item");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !stat.count_zero)
    else $error("search over an empty list");

endmodule

>>> rtl/free_page_block_cache.sv
// Top level of the free page block cache: controller, datapath and port wiring.
`timescale 1ns / 1ps
// Free page block cache. Holds an oldest-first list of up to 32 freed page
// blocks with their running page total. One item is worked at a time; the
// input is taken only when the previous item has put out its final result,
// but that result may still sit in the output register while the next item
// is accepted. Allocates that miss without a search, bypassed or rejected
// frees and undefined items answer from the decode state. A search compares
// one entry per cycle; a cached free puts out one eviction per cycle while
// the output is not stalled, then its cached result; release-all puts out one
// released block per cycle while the output is not stalled. The longest item
// is a free that evicts all 32 blocks. A hit removes its entry and closes the
// gap. The list needs no clearing pass after reset. Configuration writes
// are always taken (cfg_ready is high) and must be made while idle; index 0
// sets the page budget, index 1 the block capacity, other indexes are
// dropped.
module free_page_block_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fpbc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fpbc_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fpbc_pkg::dp_cmd_t  cmd;
  fpbc_pkg::dp_stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // Sequence each item and hold its results for the consumer.
  fpbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Keep the block list, totals and config; report decisions back.
  fpbc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> sim/free_page_block_cache_tb.sv
// Testbench for the free page block cache: predictor scoreboard, random traffic, checks.
`timescale 1ns / 1ps
module free_page_block_cache_tb;
  import fpbc_pkg::*;

  // Bound the run well past the slowest legal pace: ~400 items, up to 33
  // results each, with the receiver stalling on most cycles.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Cycles to let pass after the last result before touching registers;
  // covers a full search or eviction sweep of the 32-entry list.
  localparam int DRAIN_CYCLES = 40;

  // Function code the block does not define; it must answer with a single
  // nothing result.
  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  // Register index the block drops.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PAGE_ADDR_BITS-1:0] page;
    logic [SIZE_BITS-1:0]      size;
  } cached_block_t;

  // Mirror of the cache list plus the queue of results still owed by the block.
  class page_cache_scoreboard;
    logic [MAXP_W-1:0] max_pages;
    logic [CAP_W-1:0]  capacity;
    cached_block_t     blocks[$];
    int unsigned       total_pages;
    out_item_t         owed[$];
    int errors, items_noted, results_checked, hits, requests, releases, cfg_writes;

    function new();
      max_pages   = MAXP_RESET;
      capacity    = CAP_RESET;
      total_pages = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      cfg_writes++;
      if (idx == CFG_MAX_PAGES) max_pages = value[MAXP_W-1:0];
      else if (idx == CFG_CAPACITY) capacity = value[CAP_W-1:0];
    endfunction

    function void owe(logic [2:0] action, logic [PAGE_ADDR_BITS-1:0] page,
                      logic [SIZE_BITS-1:0] size, logic last);
      out_item_t r;
      r.action         = action;
      r.block_page_res = page;
      r.size_pages_res = size;
      r.last           = last;
      owed.push_back(r);
      if (action == ACT_HIT) hits++;
      if (action == ACT_REQUEST) requests++;
      if (action == ACT_RELEASE) releases++;
    endfunction

    // Work out the results of one accepted item and advance the mirror.
    function void note_input(in_item_t item);
      logic [SIZE_BITS-1:0] quarter;
      int cap;
      int idx;
      quarter = SIZE_BITS'(max_pages >> 2);
      items_noted++;
      case (item.func)
        FUNC_ALLOC: begin
          idx = -1;
          if (blocks.size() != 0 && item.size_pages <= quarter)
            for (int i = 0; i < blocks.size(); i++)
              if (idx < 0 && blocks[i].size == item.size_pages) idx = i;
          if (idx >= 0) begin
            owe(ACT_HIT, blocks[idx].page, item.size_pages, 1'b1);
            total_pages -= blocks[idx].size;
            blocks.delete(idx);
          end else begin
            owe(ACT_REQUEST, '0, item.size_pages, 1'b1);
          end
        end
        FUNC_FREE: begin
          if (item.size_pages == 0) begin
            owe(ACT_NOTHING, '0, '0, 1'b1);
          end else if (item.size_pages > quarter) begin
            owe(ACT_RELEASE, item.block_page, item.size_pages, 1'b1);
          end else begin
            cap = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
            // Evict oldest first while the list is full or the new block overflows the budget.
            while (blocks.size() != 0 &&
                   (blocks.size() >= cap || total_pages + item.size_pages > max_pages)) begin
              owe(ACT_RELEASE, blocks[0].page, blocks[0].size, 1'b0);
              total_pages -= blocks[0].size;
              void'(blocks.pop_front());
            end
            if (blocks.size() < ENTRIES) begin
              blocks.push_back('{page: item.block_page, size: item.size_pages});
              total_pages += item.size_pages;
            end
            owe(ACT_CACHED, item.block_page, item.size_pages, 1'b1);
          end
        end
        FUNC_RELEASE: begin
          if (blocks.size() == 0) owe(ACT_NOTHING, '0, '0, 1'b1);
          for (int i = 0; i < blocks.size(); i++)
            owe(ACT_RELEASE, blocks[i].page, blocks[i].size, i == blocks.size() - 1);
          blocks.delete();
          total_pages = 0;
        end
        default: owe(ACT_NOTHING, '0, '0, 1'b1);
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (owed.size() == 0) begin
        $error("result with nothing owed: action %0d page %h size %0d last %0b",
               got.action, got.block_page_res, got.size_pages_res, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.block_page_res !== want.block_page_res) begin
        $error("block_page_res: expected %h, got %h", want.block_page_res, got.block_page_res);
        errors++;
      end
      if (got.size_pages_res !== want.size_pages_res) begin
        $error("size_pages_res: expected %0d, got %0d", want.size_pages_res, got.size_pages_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  page_cache_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  free_page_block_cache u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Check every result taken at this edge against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver back-pressure: switch between always ready, coin flips, one
  // cycle in four and rare stalls, each for a random stretch.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'($urandom_range(0, 1));
      2:       out_ready = (rx_left % 4 == 0);
      default: out_ready = ($urandom_range(0, 7) != 0);
    endcase
  end

  // Hard stop if the block hangs or drops a result.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("free_page_block_cache verification failed");
    $finish;
  end

  function automatic in_item_t item_of(logic [1:0] func, logic [SIZE_BITS-1:0] size,
                                       logic [PAGE_ADDR_BITS-1:0] page);
    in_item_t item;
    item.func       = func;
    item.size_pages = size;
    item.block_page = page;
    return item;
  endfunction

  // Favor a small pool of sizes so allocates hit, with zero, the bypass
  // boundary and full-width noise mixed in.
  function automatic logic [SIZE_BITS-1:0] pick_size(logic [SIZE_BITS-1:0] quarter);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 14) return SIZE_BITS'($urandom());
    if (roll < 22) return quarter + SIZE_BITS'($urandom_range(0, 1));
    if (roll < 30 && quarter > 1) return SIZE_BITS'($urandom_range(1, quarter));
    return SIZE_BITS'($urandom_range(1, (quarter >= 8 || quarter == 0) ? 8 : quarter));
  endfunction

  function automatic in_item_t pick_item(int alloc_w, int free_w);
    in_item_t item;
    int unsigned roll;
    logic [SIZE_BITS-1:0] quarter;
    roll            = $urandom_range(0, 99);
    quarter         = SIZE_BITS'(sb.max_pages >> 2);
    item.block_page = $urandom();
    item.size_pages = SIZE_BITS'($urandom());
    if (roll < alloc_w) begin
      item.func = FUNC_ALLOC;
      // Most allocates ask for a size that sits in the list right now.
      if (sb.blocks.size() != 0 && $urandom_range(0, 3) != 0)
        item.size_pages = sb.blocks[$urandom_range(0, sb.blocks.size() - 1)].size;
      else
        item.size_pages = pick_size(quarter);
    end else if (roll < alloc_w + free_w) begin
      item.func       = FUNC_FREE;
      item.size_pages = pick_size(quarter);
    end else if (roll < 98) begin
      item.func = FUNC_RELEASE;
    end else begin
      item.func = FUNC_UNDEF;
    end
    return item;
  endfunction

  // Offer one item and hold it until taken. Bursts of random length are
  // separated by idle gaps; valid stays high across back-to-back items.
  task automatic send(input in_item_t item);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
    in_data  = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold the sender until every owed result has come, then let the block settle.
  task automatic wait_drained();
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int count, input int alloc_w, input int free_w);
    repeat (count) begin
      send(pick_item(alloc_w, free_w));
      // Now and then drain completely mid-phase.
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: budget 16384, so the bypass
    // boundary sits at 4096 pages.
    send(item_of(FUNC_RELEASE, '0, '0));               // release-all, empty list
    send(item_of(FUNC_UNDEF, '1, '1));                 // undefined function code
    send(item_of(FUNC_ALLOC, '0, '0));                 // allocate size zero, empty
    send(item_of(FUNC_FREE, '0, 32'h5555_AAAA));       // free size zero
    send(item_of(FUNC_FREE, '1, '1));                  // largest block bypasses
    send(item_of(FUNC_FREE, 20'd4097, '0));            // just over a quarter bypasses
    send(item_of(FUNC_FREE, 20'd4096, '1));            // exactly a quarter is cached
    send(item_of(FUNC_FREE, 20'd1, '0));
    send(item_of(FUNC_FREE, 20'd7, 32'h1234_5678));
    send(item_of(FUNC_FREE, 20'd7, 32'h9ABC_DEF0));
    send(item_of(FUNC_ALLOC, 20'd7, '0));              // first exact match wins
    send(item_of(FUNC_ALLOC, '0, '0));                 // size zero never hits
    send(item_of(FUNC_ALLOC, 20'd4097, '0));           // too large to look up
    send(item_of(FUNC_ALLOC, 20'd4096, '0));           // hit at the quarter boundary
    send(item_of(FUNC_ALLOC, 20'd9, '0));              // miss
    send(item_of(FUNC_RELEASE, '0, '0));               // release what is left
    send(item_of(FUNC_RELEASE, '1, '1));               // empty again
    repeat (5) send(item_of(FUNC_FREE, 20'd4096, $urandom()));  // fifth one overflows budget
    send(item_of(FUNC_ALLOC, '1, '0));                 // largest allocate
    run_random(60, 38, 52);

    // Small budget and capacity: evictions by count and by pages.
    wait_drained();
    write_reg(CFG_MAX_PAGES, 20'd64);
    write_reg(CFG_CAPACITY, 20'd4);
    run_random(60, 38, 52);

    // Zero budget: every free of nonzero size bypasses; the dropped index must change nothing.
    wait_drained();
    write_reg(CFG_MAX_PAGES, '0);
    write_reg(CFG_CAPACITY, 20'd63);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    run_random(40, 38, 52);

    // Full budget with capacity zero, which must behave as one.
    wait_drained();
    write_reg(CFG_MAX_PAGES, '1);
    write_reg(CFG_CAPACITY, '0);
    run_random(40, 38, 52);

    // Capacity over the store depth; lean on frees to fill all entries.
    wait_drained();
    write_reg(CFG_CAPACITY, 20'd63);
    run_random(70, 15, 83);

    // Drop the budget under the cached total: the next cached free flushes old blocks.
    wait_drained();
    write_reg(CFG_MAX_PAGES, 20'd40);
    write_reg(CFG_CAPACITY, 20'd1);
    run_random(50, 38, 52);

    wait_drained();
    write_reg(CFG_MAX_PAGES, CFG_DATA_W'($urandom_range(16, 300)));
    write_reg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(2, 31)));
    run_random(50, 38, 52);

    wait_drained();
    $display("Ran %0d items over %0d register writes; checked %0d results.",
             sb.items_noted, sb.cfg_writes, sb.results_checked);
    $display("Saw %0d hits, %0d fresh requests and %0d released blocks.",
             sb.hits, sb.requests, sb.releases);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("free_page_block_cache verification clean");
    else
      $display("free_page_block_cache verification failed");
    $finish;
  end

endmodule
